// ----- design/sal_pkg.sv -----
// Shared types, constants and helper functions for the spawn admission limiter.
`default_nettype none

package sal_pkg;

    // Sizing of the block
    localparam int WINDOW_FRAMES = 20;
    localparam int NOTE_RANGE    = 128;  // power of two: note numbers wrap by masking
    localparam int SLOT_BITS     = 16;

    // Field widths
    localparam int OP_W        = 2;
    localparam int NOTE_W      = 7;
    localparam int MODE_W      = 2;
    localparam int LIMIT_W     = 16;
    localparam int PER_NOTE_W  = 8;
    localparam int LEVEL_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int ADMIT_W     = 16;

    // Derived widths
    localparam int NOTE_AW  = $clog2(NOTE_RANGE);
    localparam int FILL_W   = $clog2(WINDOW_FRAMES + 1);
    localparam int POS_W    = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int SUM_W    = $clog2(WINDOW_FRAMES * ((1 << ADMIT_W) - 1) + 1);

    // Budget: refuse once admits >= floor(limit * factor / BUDGET_DEN),
    // checked as BUDGET_DEN * (admits + 1) > limit * factor.
    localparam int BUDGET_DEN     = 20;
    localparam int FACTOR_STEP    = 3;
    localparam int FACTOR_MIN     = 5;
    localparam int LEVEL_FLOOR    = 5;
    localparam int FACTOR_W       = $clog2(BUDGET_DEN + 1);
    localparam int SCALED_W       = $clog2(BUDGET_DEN * (1 << ADMIT_W) + 1);
    localparam logic [ADMIT_W-1:0] ADMIT_MAX = '1;

    // Overload thresholds
    localparam int THR_SINGLE = 660;
    localparam int THR_Q0     = 128;
    localparam int THR_Q1     = 256;
    localparam int THR_Q2     = 384;
    localparam int THR_Q3     = 512;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NOTE      = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME_END = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET     = 2'd2;

    // Limit modes
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PER_NOTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONE_THR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FOUR_THR  = 2'd3;

    // Latched threshold sets
    localparam logic [1:0] THR_NONE = 2'd0;
    localparam logic [1:0] THR_ONE  = 2'd1;
    localparam logic [1:0] THR_FOUR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_NOTE_LIMIT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0]     MODE_RESET     = MODE_PER_NOTE;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 16'd2500;
    localparam logic [PER_NOTE_W-1:0] PER_NOTE_RESET = 8'd1;

    typedef logic [NOTE_AW-1:0] t_note_addr;

    // Control from the item datapath to the window
    typedef struct packed {
        logic              update;   // frame end or reset command transfers this cycle
        logic              restart;  // reset command: empty window, latch thresholds
        logic [MODE_W-1:0] mode;
    } t_win_ctrl;

    function automatic logic [FACTOR_W-1:0] budget_factor(input logic [LEVEL_W-1:0] level);
        logic [FACTOR_W-1:0] f;
        if (level >= LEVEL_W'(LEVEL_FLOOR)) begin
            f = FACTOR_W'(FACTOR_MIN);
        end else begin
            f = FACTOR_W'(BUDGET_DEN) - FACTOR_W'(FACTOR_STEP) * FACTOR_W'(level);
        end
        return f;
    endfunction

    function automatic logic [LEVEL_W-1:0] count_levels(input logic [1:0] thr,
                                                         input logic [SUM_W-1:0] sum);
        logic [LEVEL_W-1:0] lv;
        case (thr)
            THR_ONE: begin
                lv = LEVEL_W'(sum > SUM_W'(THR_SINGLE));
            end
            THR_FOUR: begin
                lv = LEVEL_W'(sum > SUM_W'(THR_Q0)) + LEVEL_W'(sum > SUM_W'(THR_Q1))
                   + LEVEL_W'(sum > SUM_W'(THR_Q2)) + LEVEL_W'(sum > SUM_W'(THR_Q3));
            end
            default: begin
                lv = '0;
            end
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

// ----- design/sal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/sal_window.sv -----
// Sliding window of per-frame admission counts, running sum and overload level.
`default_nettype none

module sal_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sal_pkg::t_win_ctrl          i_ctrl,
    input  wire logic [sal_pkg::ADMIT_W-1:0] i_admits,
    output logic      [sal_pkg::LEVEL_W-1:0] o_level,
    output logic      [sal_pkg::LEVEL_W-1:0] o_level_next
);
    import sal_pkg::*;

    logic [ADMIT_W-1:0] r_ring [WINDOW_FRAMES];
    logic [FILL_W-1:0]  r_fill,  n_fill;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [SUM_W-1:0]   r_sum,   n_sum;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [1:0]         r_thr,   n_thr;

    logic [FILL_W-1:0]  base_fill;
    logic [POS_W-1:0]   base_pos;
    logic [SUM_W-1:0]   base_sum;
    logic [SUM_W-1:0]   sum_drop;
    logic               win_full;
    logic               push;

    always_comb begin
        base_fill = i_ctrl.restart ? '0 : r_fill;
        base_pos  = i_ctrl.restart ? '0 : r_pos;
        base_sum  = i_ctrl.restart ? '0 : r_sum;
        win_full  = base_fill >= FILL_W'(WINDOW_FRAMES);
        push      = i_ctrl.update &&
                    (i_ctrl.mode == MODE_ONE_THR || i_ctrl.mode == MODE_FOUR_THR);
        sum_drop  = win_full ? base_sum - SUM_W'(r_ring[base_pos]) : base_sum;

        n_thr = r_thr;
        if (i_ctrl.restart) begin
            case (i_ctrl.mode)
                MODE_ONE_THR:  n_thr = THR_ONE;
                MODE_FOUR_THR: n_thr = THR_FOUR;
                default:       n_thr = THR_NONE;
            endcase
        end

        n_fill  = i_ctrl.update ? base_fill : r_fill;
        n_pos   = i_ctrl.update ? base_pos  : r_pos;
        n_sum   = i_ctrl.update ? base_sum  : r_sum;
        n_level = r_level;
        if (push) begin
            n_fill  = win_full ? base_fill : base_fill + FILL_W'(1);
            n_pos   = (base_pos == POS_W'(WINDOW_FRAMES - 1)) ? '0 : base_pos + POS_W'(1);
            n_sum   = sum_drop + SUM_W'(i_admits);
            n_level = count_levels(n_thr, n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_level <= '0;
            r_thr   <= THR_NONE;
        end else begin
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_level <= n_level;
            r_thr   <= n_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ring[base_pos] <= i_admits;
        end
    end

    assign o_level      = r_level;
    assign o_level_next = n_level;

endmodule

`default_nettype wire

// ----- design/spawn_admission_limiter.sv -----
// Spawn admission limiter: top level with item datapath and configuration registers.
// Pipeline: each item passes through the input register, then the result register.
// Throughput: one item per cycle while the result channel does not stall; set by the
//   read-modify-write of the per-note count RAM, with a forwarding register covering back-to-back notes.
// Reset (synchronous, active low): configuration returns to mode 1, limit 2500,
//   per-note limit 1; counters, window and pool clear at once, with no clearing pass.
`default_nettype none

module spawn_admission_limiter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [sal_pkg::OP_W-1:0]       i_operation,
    input  wire logic [sal_pkg::NOTE_W-1:0]     i_note,
    // Result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_accepted,
    output logic      [sal_pkg::SLOT_BITS-1:0]  o_slot,
    output logic                                o_slot_is_new,
    output logic      [sal_pkg::LEVEL_W-1:0]    o_overload_level,
    // Configuration write port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [sal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sal_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sal_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]     r_limit_mode;
    logic [LIMIT_W-1:0]    r_block_limit;
    logic [PER_NOTE_W-1:0] r_per_note_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_mode     <= MODE_RESET;
            r_block_limit    <= LIMIT_RESET;
            r_per_note_limit <= PER_NOTE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LIMIT_MODE:     r_limit_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_LIMIT:    r_block_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_PER_NOTE_LIMIT: r_per_note_limit <= i_cfg_data[PER_NOTE_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. The input side
    // stalls only when an item sits in the input register and cannot move on.
    // ------------------------------------------------------------------
    logic            r_in_valid;
    logic [OP_W-1:0] r_op;
    t_note_addr      r_note;
    logic            r_out_valid;
    logic            w_advance;
    logic            w_in_xfer;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_in_xfer = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Per-note counts: RAM read at input transfer, written when the item
    // advances. A valid bit per note gives flash clear at frame end or reset; a
    // forwarding register catches a write to the address being read.
    // ------------------------------------------------------------------
    logic [NOTE_RANGE-1:0] r_cnt_valid;
    logic                  r_fwd_hit;
    logic [COUNT_W-1:0]    r_fwd_data;
    logic [COUNT_W-1:0]    w_ram_q;
    logic                  w_ram_we;
    logic [COUNT_W-1:0]    w_ram_wdata;
    logic [COUNT_W-1:0]    w_cnt_raw;
    logic [COUNT_W-1:0]    w_cnt;

    sal_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NOTE_RANGE)
    ) u_note_counts (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_note),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (i_note[NOTE_AW-1:0]),
        .o_rd_data (w_ram_q)
    );

    assign w_cnt_raw = r_fwd_hit ? r_fwd_data : w_ram_q;
    assign w_cnt     = r_cnt_valid[r_note] ? w_cnt_raw : '0;

    // ------------------------------------------------------------------
    // Frame state and slot ring
    // ------------------------------------------------------------------
    logic [ADMIT_W-1:0]   r_frame_admits, n_frame_admits;
    logic [SCALED_W-1:0]  r_admit_scaled, n_admit_scaled;  // BUDGET_DEN * (admits + 1)
    logic [SLOT_BITS-1:0] r_next_slot,    n_next_slot;
    logic                 r_pool_full,    n_pool_full;
    logic [NOTE_RANGE-1:0] n_cnt_valid;

    // Overload window
    t_win_ctrl          w_win_ctrl;
    logic [LEVEL_W-1:0] w_level;
    logic [LEVEL_W-1:0] w_level_next;

    sal_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_win_ctrl),
        .i_admits     (r_frame_admits),
        .o_level      (w_level),
        .o_level_next (w_level_next)
    );

    // Item datapath
    logic [SCALED_W-1:0]  w_budget_prod;
    logic                 w_ok;
    logic                 w_admit;
    logic [LIMIT_W-1:0]   w_bl;
    logic                 w_wrap_pre;
    logic [SLOT_BITS-1:0] w_slot;
    logic                 w_full_pre;
    logic [SLOT_BITS:0]   w_slot_inc;
    logic [SLOT_BITS-1:0] w_slot_nxt;
    logic                 w_wrap_post;

    always_comb begin
        // Budget check for the window modes, free of division
        w_budget_prod = SCALED_W'(r_block_limit) * SCALED_W'(budget_factor(w_level));

        case (r_limit_mode)
            MODE_PER_NOTE:               w_ok = w_cnt < r_per_note_limit;
            MODE_ONE_THR, MODE_FOUR_THR: w_ok = !(r_admit_scaled > w_budget_prod);
            default:                     w_ok = 1'b1;
        endcase
        w_admit = (r_op == OP_NOTE) && w_ok;

        // Slot ring: a zero limit behaves as one; wrap before and after the take
        w_bl        = (r_block_limit == '0) ? LIMIT_W'(1) : r_block_limit;
        w_wrap_pre  = (LIMIT_W + 1)'(r_next_slot) >= (LIMIT_W + 1)'(w_bl);
        w_slot      = w_wrap_pre ? '0 : r_next_slot;
        w_full_pre  = r_pool_full || w_wrap_pre;
        w_slot_inc  = (SLOT_BITS + 1)'(w_slot) + (SLOT_BITS + 1)'(1);
        w_slot_nxt  = w_slot_inc[SLOT_BITS-1:0];
        w_wrap_post = ((LIMIT_W + 1)'(w_slot_nxt) >= (LIMIT_W + 1)'(w_bl))
                   || (w_slot_nxt == '0);

        w_ram_we    = w_advance && w_admit && (r_limit_mode == MODE_PER_NOTE);
        w_ram_wdata = w_cnt + COUNT_W'(1);

        w_win_ctrl.update  = w_advance && (r_op == OP_FRAME_END || r_op == OP_RESET);
        w_win_ctrl.restart = w_advance && (r_op == OP_RESET);
        w_win_ctrl.mode    = r_limit_mode;

        // Hold by default
        n_frame_admits = r_frame_admits;
        n_admit_scaled = r_admit_scaled;
        n_next_slot    = r_next_slot;
        n_pool_full    = r_pool_full;
        n_cnt_valid    = r_cnt_valid;

        if (w_advance) begin
            case (r_op)
                OP_NOTE: begin
                    if (w_admit) begin
                        n_next_slot = w_wrap_post ? '0 : w_slot_nxt;
                        n_pool_full = w_full_pre || w_wrap_post;
                        // saturate the frame count
                        if (r_frame_admits != ADMIT_MAX) begin
                            n_frame_admits = r_frame_admits + ADMIT_W'(1);
                            n_admit_scaled = r_admit_scaled + SCALED_W'(BUDGET_DEN);
                        end
                        if (w_ram_we) begin
                            n_cnt_valid[r_note] = 1'b1;
                        end
                    end
                end
                OP_FRAME_END: begin
                    n_frame_admits = '0;
                    n_admit_scaled = SCALED_W'(BUDGET_DEN);
                    n_cnt_valid    = '0;
                end
                OP_RESET: begin
                    n_frame_admits = '0;
                    n_admit_scaled = SCALED_W'(BUDGET_DEN);
                    n_cnt_valid    = '0;
                    n_next_slot    = '0;
                    n_pool_full    = 1'b0;
                end
                default: ;  // unused operation: change nothing
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_frame_admits <= '0;
            r_admit_scaled <= SCALED_W'(BUDGET_DEN);
            r_next_slot    <= '0;
            r_pool_full    <= 1'b0;
            r_cnt_valid    <= '0;
        end else begin
            r_in_valid     <= w_in_xfer || (r_in_valid && !w_advance);
            r_out_valid    <= w_advance || (r_out_valid && i_stall);
            r_frame_admits <= n_frame_admits;
            r_admit_scaled <= n_admit_scaled;
            r_next_slot    <= n_next_slot;
            r_pool_full    <= n_pool_full;
            r_cnt_valid    <= n_cnt_valid;
        end
    end

    // Input register payload and forwarding capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op       <= i_operation;
            r_note     <= i_note[NOTE_AW-1:0];
            r_fwd_hit  <= w_ram_we && (r_note == i_note[NOTE_AW-1:0]);
            r_fwd_data <= w_ram_wdata;
        end
    end

    // Result register payload
    logic                 r_accepted;
    logic [SLOT_BITS-1:0] r_slot;
    logic                 r_slot_is_new;
    logic [LEVEL_W-1:0]   r_level;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_accepted    <= w_admit;
            r_slot        <= w_admit ? w_slot : '0;
            r_slot_is_new <= w_admit && !w_full_pre;
            r_level       <= w_level_next;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_slot           = r_slot;
    assign o_slot_is_new    = r_slot_is_new;
    assign o_overload_level = r_level;

`ifndef SYNTH
    // An admitted slot lies inside the ring, or is the wrapped slot zero
    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_slot == '0 || o_slot < r_block_limit))
        else $error("slot outside the ring");

    // A refusal carries neither slot nor new flag
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_slot == '0 && !o_slot_is_new))
        else $error("refused item carries a slot");

    // The overload level never exceeds the number of thresholds
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LEVEL_W'(4))
        else $error("overload level out of range");

    // A delivered result with nothing behind it empties the result register
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !w_advance) |=> !o_valid)
        else $error("result repeated");
`endif

endmodule

`default_nettype wire

// ----- bench/admission_scoreboard.sv -----
// Scoreboard for the spawn admission limiter: predicts every verdict and compares it.

module admission_scoreboard (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    input  wire logic                           i_item_stall,
    input  wire logic [sal_pkg::OP_W-1:0]       i_operation,
    input  wire logic [sal_pkg::NOTE_W-1:0]     i_note,
    input  wire logic                           i_verdict_valid,
    input  wire logic                           i_verdict_stall,
    input  wire logic                           i_accepted,
    input  wire logic [sal_pkg::SLOT_BITS-1:0]  i_slot,
    input  wire logic                           i_slot_is_new,
    input  wire logic [sal_pkg::LEVEL_W-1:0]    i_level,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [sal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sal_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import sal_pkg::*;

    typedef struct packed {
        logic                 accepted;
        logic [SLOT_BITS-1:0] slot;
        logic                 slot_is_new;
        logic [LEVEL_W-1:0]   level;
    } t_verdict;

    // Room for every verdict that can be in flight, with margin
    localparam int PEND_DEPTH = 8;

    // Configuration copy
    logic [MODE_W-1:0]     mode_q;
    logic [LIMIT_W-1:0]    limit_q;
    logic [PER_NOTE_W-1:0] per_note_q;

    // Admission state
    logic [COUNT_W-1:0]  note_uses [NOTE_RANGE];
    logic [ADMIT_W-1:0]  frame_hist [WINDOW_FRAMES];
    int unsigned         hist_fill;
    int unsigned         hist_pos;
    int unsigned         hist_total;
    logic [LEVEL_W-1:0]  overload;
    int unsigned         admits_this_frame;
    int unsigned         slot_cursor;
    bit                  ring_wrapped;
    logic [1:0]          thr_sel;

    // Predicted verdicts in transfer order
    t_verdict    pend_buf [PEND_DEPTH];
    int unsigned pend_head;
    int unsigned pend_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        o_mismatches++;
    endtask

    function automatic logic [LEVEL_W-1:0] level_for(input logic [1:0] sel,
                                                      input int unsigned total);
        int unsigned        steps [4];
        logic [LEVEL_W-1:0] lv;
        steps = '{THR_Q0, THR_Q1, THR_Q2, THR_Q3};
        lv = '0;
        if (sel == THR_ONE) begin
            if (total > THR_SINGLE) lv = LEVEL_W'(1);
        end else if (sel == THR_FOUR) begin
            foreach (steps[k]) begin
                if (total > steps[k]) lv++;
            end
        end
        return lv;
    endfunction

    // Push the frame into the window (threshold modes only), then clear the frame.
    task automatic close_frame();
        if (mode_q == MODE_ONE_THR || mode_q == MODE_FOUR_THR) begin
            if (hist_fill >= WINDOW_FRAMES) begin
                hist_total -= frame_hist[hist_pos];
            end else begin
                hist_fill++;
            end
            frame_hist[hist_pos] = ADMIT_W'(admits_this_frame);
            hist_total += admits_this_frame;
            hist_pos = (hist_pos + 1) % WINDOW_FRAMES;
            overload = level_for(thr_sel, hist_total);
        end
        foreach (note_uses[n]) note_uses[n] = '0;
        admits_this_frame = 0;
    endtask

    task automatic restart_pool();
        hist_fill  = 0;
        hist_pos   = 0;
        hist_total = 0;
        if (mode_q == MODE_ONE_THR) thr_sel = THR_ONE;
        else if (mode_q == MODE_FOUR_THR) thr_sel = THR_FOUR;
        else thr_sel = THR_NONE;
        slot_cursor  = 0;
        ring_wrapped = 1'b0;
        close_frame();
    endtask

    task automatic predict_admission(input logic [OP_W-1:0] op,
                                     input logic [NOTE_W-1:0] nt,
                                     output t_verdict v);
        int unsigned factor;
        int unsigned budget;
        int unsigned lim;
        int unsigned span;
        int unsigned idx;
        bit          admit;
        v     = '0;
        admit = 1'b1;
        lim   = limit_q;
        idx   = nt % NOTE_RANGE;
        case (op)
            OP_NOTE: begin
                if (mode_q == MODE_PER_NOTE) begin
                    if (note_uses[idx] >= per_note_q) admit = 1'b0;
                    else note_uses[idx]++;
                end else if (mode_q == MODE_ONE_THR || mode_q == MODE_FOUR_THR) begin
                    if (FACTOR_STEP * overload >= BUDGET_DEN - FACTOR_MIN) begin
                        factor = FACTOR_MIN;
                    end else begin
                        factor = BUDGET_DEN - FACTOR_STEP * overload;
                    end
                    budget = (lim * factor) / BUDGET_DEN;
                    if (admits_this_frame >= budget) admit = 1'b0;
                end
                if (admit) begin
                    span = (lim == 0) ? 1 : lim;
                    if (slot_cursor >= span) begin
                        slot_cursor  = 0;
                        ring_wrapped = 1'b1;
                    end
                    v.accepted    = 1'b1;
                    v.slot        = SLOT_BITS'(slot_cursor);
                    v.slot_is_new = !ring_wrapped;
                    slot_cursor   = (slot_cursor + 1) & ((1 << SLOT_BITS) - 1);
                    if (slot_cursor >= span || slot_cursor == 0) begin
                        slot_cursor  = 0;
                        ring_wrapped = 1'b1;
                    end
                    if (admits_this_frame < ADMIT_MAX) admits_this_frame++;
                end
            end
            OP_FRAME_END: close_frame();
            OP_RESET:     restart_pool();
            default: ;
        endcase
        v.level = overload;
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            mode_q     = MODE_RESET;
            limit_q    = LIMIT_RESET;
            per_note_q = PER_NOTE_RESET;
            foreach (note_uses[n]) note_uses[n] = '0;
            foreach (frame_hist[f]) frame_hist[f] = '0;
            hist_fill         = 0;
            hist_pos          = 0;
            hist_total        = 0;
            overload          = '0;
            admits_this_frame = 0;
            slot_cursor       = 0;
            ring_wrapped      = 1'b0;
            thr_sel           = THR_NONE;
            pend_head         = 0;
            pend_count        = 0;
            o_mismatches      = 0;
            o_outstanding    <= 0;
        end else begin
            if (i_verdict_valid && !i_verdict_stall) begin
                got = '{i_accepted, i_slot, i_slot_is_new, i_level};
                if (pend_count == 0) begin
                    report_mismatch("verdict with none predicted, slot", got.slot, 0);
                end else begin
                    want       = pend_buf[pend_head];
                    pend_head  = (pend_head + 1) % PEND_DEPTH;
                    pend_count--;
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.slot !== want.slot)
                        report_mismatch("slot", got.slot, want.slot);
                    if (got.slot_is_new !== want.slot_is_new)
                        report_mismatch("slot_is_new", got.slot_is_new, want.slot_is_new);
                    if (got.level !== want.level)
                        report_mismatch("overload_level", got.level, want.level);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LIMIT_MODE:     mode_q     = i_cfg_data[MODE_W-1:0];
                    CFG_BLOCK_LIMIT:    limit_q    = i_cfg_data[LIMIT_W-1:0];
                    CFG_PER_NOTE_LIMIT: per_note_q = i_cfg_data[PER_NOTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_item_valid && !i_item_stall) begin
                predict_admission(i_operation, i_note, want);
                if (pend_count == PEND_DEPTH) begin
                    report_mismatch("verdicts in flight", pend_count, PEND_DEPTH - 1);
                end else begin
                    pend_buf[(pend_head + pend_count) % PEND_DEPTH] = want;
                    pend_count++;
                end
            end
            o_outstanding <= pend_count;
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the spawn admission limiter: stimulus, idling and the verdict.

module tb;
    import sal_pkg::*;

    // Operation code the block does not use; it must change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 1_500_000;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  item_valid    = 1'b0;
    logic                  item_stall;
    logic [OP_W-1:0]       item_op       = OP_NOTE;
    logic [NOTE_W-1:0]     item_note     = '0;
    logic                  verdict_valid;
    logic                  verdict_stall = 1'b0;
    logic                  v_accepted;
    logic [SLOT_BITS-1:0]  v_slot;
    logic                  v_slot_is_new;
    logic [LEVEL_W-1:0]    v_level;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_LIMIT_MODE;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    bit idle_en = 1'b1;  // random idling on both channels
    int mismatches;
    int outstanding;

    spawn_admission_limiter dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (item_valid),
        .o_stall          (item_stall),
        .i_operation      (item_op),
        .i_note           (item_note),
        .o_valid          (verdict_valid),
        .i_stall          (verdict_stall),
        .o_accepted       (v_accepted),
        .o_slot           (v_slot),
        .o_slot_is_new    (v_slot_is_new),
        .o_overload_level (v_level),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    admission_scoreboard u_admission_sb (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_item_valid    (item_valid),
        .i_item_stall    (item_stall),
        .i_operation     (item_op),
        .i_note          (item_note),
        .i_verdict_valid (verdict_valid),
        .i_verdict_stall (verdict_stall),
        .i_accepted      (v_accepted),
        .i_slot          (v_slot),
        .i_slot_is_new   (v_slot_is_new),
        .i_level         (v_level),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: end the run if the stimulus or the drain hangs.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stall the verdict channel at random, about one time in ten, while idling is on.
    always @(posedge clk) begin
        verdict_stall <= idle_en && ($urandom_range(99, 0) < 10);
    end

    // Mostly a handful of neighbouring notes so per-note limits bite, sometimes any note.
    function automatic logic [NOTE_W-1:0] random_note();
        if ($urandom_range(2, 0) == 0) return NOTE_W'($urandom_range(NOTE_RANGE - 1, 0));
        return NOTE_W'($urandom_range(63, 60));
    endfunction

    // Offer one item and hold it until the block takes the transfer. An optional
    // gap goes first; valid is left high afterwards so back-to-back items never
    // see valid dropped and raised in the same step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] nt);
        int gap;
        if (idle_en && $urandom_range(99, 0) < 10) begin
            item_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_op    <= op;
        item_note  <= nt;
        do @(posedge clk); while (item_stall);
    endtask

    // Drop valid and wait until every predicted verdict has been seen, then
    // let the two-stage pipeline settle.
    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Reprogram all three registers once the block is idle.
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [LIMIT_W-1:0] lim,
                             input logic [PER_NOTE_W-1:0] per_note);
        drain();
        cfg_write(CFG_LIMIT_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_BLOCK_LIMIT, CFG_DATA_W'(lim));
        cfg_write(CFG_PER_NOTE_LIMIT, CFG_DATA_W'(per_note));
    endtask

    // Fill the current frame with unlimited admissions, then switch to the
    // target mode and issue a reset command, which latches the thresholds and
    // pushes that frame as the window's first entry.
    task automatic preload_window(input logic [MODE_W-1:0] mode, input logic [LIMIT_W-1:0] lim,
                                  input logic [PER_NOTE_W-1:0] per_note, input int count);
        configure(MODE_NONE, lim, per_note);
        repeat (count) send_item(OP_NOTE, random_note());
        configure(mode, lim, per_note);
        send_item(OP_RESET, random_note());
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0]     mode_plan [10];
        logic [MODE_W-1:0]     mode;
        logic [LIMIT_W-1:0]    lim;
        logic [PER_NOTE_W-1:0] per_note;
        int                    frames;

        mode_plan = '{MODE_PER_NOTE, MODE_FOUR_THR, MODE_NONE, MODE_ONE_THR, MODE_FOUR_THR,
                      MODE_PER_NOTE, MODE_ONE_THR, MODE_FOUR_THR, MODE_NONE, MODE_FOUR_THR};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset configuration is per-note mode, limit one per note.
        send_item(OP_NOTE, 7'd0);
        send_item(OP_NOTE, 7'd0);          // second in the frame: refuse
        send_item(OP_NOTE, 7'd127);
        send_item(OP_NOTE, 7'd127);
        send_item(OP_UNUSED, 7'd127);      // unused code: no effect
        send_item(OP_FRAME_END, 7'd0);
        send_item(OP_NOTE, 7'd0);          // counts cleared: admit again
        send_item(OP_RESET, 7'd0);

        // Per-note limit of zero refuses everything.
        configure(MODE_PER_NOTE, 16'd3, 8'd0);
        send_item(OP_NOTE, 7'd5);

        // One-slot ring, then a zero limit that must behave as one.
        configure(MODE_NONE, 16'd1, 8'd255);
        send_item(OP_NOTE, 7'd1);
        send_item(OP_NOTE, 7'd2);
        configure(MODE_NONE, 16'd0, 8'd255);
        send_item(OP_NOTE, 7'd3);

        // Four thresholds with a budget of two per frame.
        configure(MODE_FOUR_THR, 16'd2, 8'd255);
        send_item(OP_RESET, 7'd0);
        send_item(OP_NOTE, 7'd10);
        send_item(OP_NOTE, 7'd11);
        send_item(OP_NOTE, 7'd12);         // over budget: refuse
        send_item(OP_FRAME_END, 7'd0);

        // Single threshold at the largest limit, then per-note at the extremes.
        configure(MODE_ONE_THR, 16'hFFFF, 8'd255);
        send_item(OP_RESET, 7'd0);
        send_item(OP_NOTE, 7'd64);
        send_item(OP_FRAME_END, 7'd0);
        configure(MODE_PER_NOTE, 16'hFFFF, 8'd255);
        repeat (3) send_item(OP_NOTE, 7'd64);

        // Random phases: each picks a setting, optionally resets the pool, then
        // runs frames of notes with a little noise mixed in.
        for (int phase = 0; phase < 10; phase++) begin
            mode = mode_plan[phase];
            case ($urandom_range(4, 0))
                0:       lim = 16'd1;
                1:       lim = LIMIT_W'($urandom_range(12, 2));
                2:       lim = LIMIT_W'($urandom_range(60, 20));
                3:       lim = 16'hFFFF;
                default: lim = LIMIT_W'($urandom_range(65535, 0));
            endcase
            case ($urandom_range(3, 0))
                0:       per_note = 8'd0;
                1:       per_note = 8'd1;
                2:       per_note = PER_NOTE_W'($urandom_range(4, 2));
                default: per_note = 8'hFF;
            endcase
            // Hold idling off for one whole phase.
            idle_en <= (phase != 4);
            frames = (phase == 4) ? 12 : $urandom_range(5, 2);

            configure(mode, lim, per_note);
            if ($urandom_range(3, 0) != 0) send_item(OP_RESET, random_note());

            repeat (frames) begin
                repeat ($urandom_range(8, 0)) begin
                    if ($urandom_range(15, 0) == 0) begin
                        send_item(($urandom_range(1, 0) == 1) ? OP_UNUSED : OP_RESET,
                                  random_note());
                    end else begin
                        send_item(OP_NOTE, random_note());
                    end
                end
                send_item(OP_FRAME_END, random_note());
            end
        end
        idle_en <= 1'b1;

        // Seed the window past the lowest threshold, then let the seeded entry
        // sit in the window and age out of it.
        preload_window(MODE_FOUR_THR, 16'hFFFF, 8'd1, 135);
        repeat (WINDOW_FRAMES + 1) begin
            repeat ($urandom_range(3, 0)) send_item(OP_NOTE, random_note());
            send_item(OP_FRAME_END, random_note());
        end

        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sal_pkg.sv
design/sal_ram.sv
design/sal_window.sv
design/spawn_admission_limiter.sv
bench/admission_scoreboard.sv
bench/tb.sv
